@@ src/rtufr_pkg.sv @@
// rtufr_pkg: constants, types and the bytewise crc-16 update for the rtu frame receiver
// no dependencies; imported by every module of the block
`default_nettype none

package rtufr_pkg;

  localparam int unsigned MaxFrameLen = 19;
  localparam int unsigned CntW        = $clog2(MaxFrameLen + 1);
  localparam int unsigned PosW        = 5;
  localparam int unsigned MinCheckLen = 4;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [7:0]  SlaveAddrRst = 8'd1;

  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic            in_frame;
    logic [PosW-1:0] byte_pos;
    logic            frame_ok;
    logic [PosW-1:0] frame_len;
    logic            frame_dropped;
  } result_t;

  function automatic logic [15:0] crc_add_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/rtufr_in_reg.sv @@
// rtufr_in_reg: input register stage holding one received byte request
// depends on rtufr_pkg
`default_nettype none

module rtufr_in_reg
  import rtufr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign rx_stall_o = valid_q & ~take_i;
  assign load       = rx_valid_i & ~rx_stall_o;
  assign valid_d    = (take_i | ~valid_q) ? rx_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

@@ src/rtufr_proc.sv @@
// rtufr_proc: frame tracking state, running crc and per-byte result logic
// depends on rtufr_pkg (crc_add_byte, result_t)
`default_nettype none

module rtufr_proc
  import rtufr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  output result_t         res_o
);

  logic        addr_hit;
  logic [7:0]  slave_address_q;
  logic        receiving_q, receiving_d;
  cnt_t        count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  newer_q, newer_d;
  logic [7:0]  older_q, older_d;
  logic        match;

  assign addr_hit = (rx_byte_i == slave_address_q);

  always_comb begin
    receiving_d = receiving_q;
    count_d     = count_q;
    crc_d       = crc_q;
    newer_d     = newer_q;
    older_d     = older_q;
    match       = 1'b0;
    res_o       = '0;
    if (!receiving_q) begin
      if (addr_hit) begin
        receiving_d    = 1'b1;
        count_d        = cnt_t'(1);
        crc_d          = CrcInit;
        older_d        = 8'h00;
        newer_d        = rx_byte_i;
        res_o.in_frame = 1'b1;
      end
    end else begin
      if (count_q >= cnt_t'(2)) begin
        crc_d = crc_add_byte(crc_q, older_q);
      end
      older_d        = newer_q;
      newer_d        = rx_byte_i;
      count_d        = count_q + cnt_t'(1);
      res_o.in_frame = 1'b1;
      res_o.byte_pos = PosW'(count_q);
      if (count_d >= cnt_t'(MinCheckLen)) begin
        match = (older_d == crc_d[7:0]) && (newer_d == crc_d[15:8]);
        if (match) begin
          res_o.frame_ok  = 1'b1;
          res_o.frame_len = PosW'(count_d);
          receiving_d     = 1'b0;
        end else if (count_d >= cnt_t'(MaxFrameLen)) begin
          res_o.frame_dropped = 1'b1;
          receiving_d         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= SlaveAddrRst;
      receiving_q     <= 1'b0;
      count_q         <= '0;
      crc_q           <= CrcInit;
      newer_q         <= 8'h00;
      older_q         <= 8'h00;
    end else begin
      if (cfg_we_i) begin
        slave_address_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        receiving_q <= receiving_d;
        count_q     <= count_d;
        crc_q       <= crc_d;
        newer_q     <= newer_d;
        older_q     <= older_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/rtufr_out_reg.sv @@
// rtufr_out_reg: result register driving the output request channel
// depends on rtufr_pkg (result_t)
`default_nettype none

module rtufr_out_reg
  import rtufr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  result_t      res_i,
  output logic         take_o,
  output logic         res_valid_o,
  input  wire logic    res_stall_i,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  assign take_o = ~valid_q | ~res_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ src/rtu_frame_receiver_crc16_core.sv @@
// rtu_frame_receiver_crc16_core: top level of the modbus rtu frame receiver
// depends on rtufr_pkg, rtufr_in_reg, rtufr_proc, rtufr_out_reg
`default_nettype none

// One received byte per request, one result per byte. A new byte can be taken
// every clock cycle unless rx_stall_o is raised; its result is registered
// when the byte leaves the input register (the crc update and compare sit
// between the input register and the result register).
// The running crc-16/modbus folds in each frame byte two accepted requests later.
// rx_stall_o follows res_stall_i combinationally when both registers are
// full. slave_address may be written only while no request is in flight.
module rtu_frame_receiver_crc16_core
  import rtufr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            rx_valid_i,
  output logic                 rx_stall_o,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 res_valid_o,
  input  wire logic            res_stall_i,
  output logic                 in_frame_o,
  output logic [PosW-1:0]      byte_pos_o,
  output logic                 frame_ok_o,
  output logic [PosW-1:0]      frame_len_o,
  output logic                 frame_dropped_o
);

  logic       take;
  logic       stage_valid;
  logic [7:0] stage_byte;
  result_t    res_comb;
  result_t    res_reg;

  rtufr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  rtufr_proc u_proc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (stage_valid & take),
    .rx_byte_i   (stage_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res_comb)
  );

  rtufr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .res_i       (res_comb),
    .take_o      (take),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_reg)
  );

  assign in_frame_o      = res_reg.in_frame;
  assign byte_pos_o      = res_reg.byte_pos;
  assign frame_ok_o      = res_reg.frame_ok;
  assign frame_len_o     = res_reg.frame_len;
  assign frame_dropped_o = res_reg.frame_dropped;

endmodule

`default_nettype wire

@@ tb/tb_rtu_frame_receiver_crc16_core.sv @@
// tb_rtu_frame_receiver_crc16_core: self-checking testbench for the rtu frame receiver core
// drives received bytes and slave address writes, predicts every result in a small scoreboard
// depends on rtufr_pkg and rtu_frame_receiver_crc16_core
module tb_rtu_frame_receiver_crc16_core;
  import rtufr_pkg::*;

  localparam int unsigned QuietLimit = 1000;

  class frame_scoreboard;
    logic [7:0]  station_addr;
    bit          receiving;
    int unsigned nbytes;
    logic [15:0] crc_acc;
    logic [7:0]  newer;
    logic [7:0]  older;
    result_t     expected[$];
    int unsigned errors;

    function new();
      station_addr = SlaveAddrRst;
      receiving    = 1'b0;
      nbytes       = 0;
      crc_acc      = CrcInit;
      newer        = '0;
      older        = '0;
      errors       = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      return c;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    // returns 1 when the byte was taken into a frame
    function bit note_request(logic [7:0] b);
      result_t r;
      r = '0;
      if (!receiving) begin
        if (b == station_addr) begin
          receiving  = 1'b1;
          nbytes     = 1;
          crc_acc    = CrcInit;
          older      = '0;
          newer      = b;
          r.in_frame = 1'b1;
        end
      end else begin
        if (nbytes >= 2) crc_acc = crc_step(crc_acc, older);
        older = newer;
        newer = b;
        nbytes++;
        r.in_frame = 1'b1;
        r.byte_pos = PosW'(nbytes - 1);
        if (nbytes >= MinCheckLen) begin
          if (older == crc_acc[7:0] && newer == crc_acc[15:8]) begin
            r.frame_ok  = 1'b1;
            r.frame_len = PosW'(nbytes);
            receiving   = 1'b0;
          end else if (nbytes >= MaxFrameLen) begin
            r.frame_dropped = 1'b1;
            receiving       = 1'b0;
          end
        end
      end
      expected.push_back(r);
      return r.in_frame;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (expected.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected result: in_frame=%0d byte_pos=%0d ok=%0d len=%0d dropped=%0d",
                   got.in_frame, got.byte_pos, got.frame_ok, got.frame_len, got.frame_dropped);
        end
        errors++;
        return;
      end
      want = expected.pop_front();
      bad = (got.in_frame !== want.in_frame) || (got.byte_pos !== want.byte_pos) ||
            (got.frame_ok !== want.frame_ok) || (got.frame_len !== want.frame_len) ||
            (got.frame_dropped !== want.frame_dropped);
      if (bad) begin
        if (errors < 10) begin
          $display("mismatch: exp in_frame=%0d byte_pos=%0d ok=%0d len=%0d dropped=%0d",
                   want.in_frame, want.byte_pos, want.frame_ok, want.frame_len,
                   want.frame_dropped);
          $display("          got in_frame=%0d byte_pos=%0d ok=%0d len=%0d dropped=%0d",
                   got.in_frame, got.byte_pos, got.frame_ok, got.frame_len, got.frame_dropped);
        end
        errors++;
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [7:0]      cfg_wdata_i = 8'h00;
  logic            rx_valid_i  = 1'b0;
  logic            rx_stall_o;
  logic [7:0]      rx_byte_i   = 8'h00;
  logic            res_valid_o;
  logic            res_stall_i = 1'b0;
  logic            in_frame_o;
  logic [PosW-1:0] byte_pos_o;
  logic            frame_ok_o;
  logic [PosW-1:0] frame_len_o;
  logic            frame_dropped_o;

  frame_scoreboard sb;
  int unsigned     tx_idle_pct   = 0;
  int unsigned     rx_idle_pct   = 0;
  int unsigned     long_hold_req = 0;
  int unsigned     hold_left     = 0;
  int unsigned     taken_bytes   = 0;
  int unsigned     quiet_cycles  = 0;

  rtu_frame_receiver_crc16_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .in_frame_o      (in_frame_o),
    .byte_pos_o      (byte_pos_o),
    .frame_ok_o      (frame_ok_o),
    .frame_len_o     (frame_len_o),
    .frame_dropped_o (frame_dropped_o)
  );

  always #2 clk_i = ~clk_i;

  // result side: check accepted results, then choose the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i) begin
        sb.check_result({in_frame_o, byte_pos_o, frame_ok_o, frame_len_o, frame_dropped_o});
      end
      if (long_hold_req != 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall_i <= 1'b1;
      end else begin
        res_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && !rx_stall_o) || (res_valid_o && !res_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    if (sb.note_request(b)) taken_bytes++;
  endtask

  // body holds the address and data; the crc is appended low byte first
  task automatic send_frame(input logic [7:0] body[$], input bit corrupt);
    logic [15:0] crc;
    crc = CrcInit;
    foreach (body[i]) crc = sb.crc_step(crc, body[i]);
    if (corrupt) crc ^= 16'(1) << $urandom_range(15);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic write_station_address(input logic [7:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.station_addr = addr;
  endtask

  task automatic finish_phase();
    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_directed();
    logic [7:0] body[$];
    send_byte(8'h00);
    send_byte(8'hFF);
    // address byte reused as frame data
    body = {sb.station_addr, sb.station_addr};
    send_frame(body, 1'b0);
    // zeros never match, so the frame runs to the length limit
    send_byte(sb.station_addr);
    repeat (MaxFrameLen - 1) send_byte(8'h00);
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n_data;
    logic [7:0]  body[$];
    stop_at = taken_bytes + n_items;
    while (taken_bytes < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        case ($urandom_range(9))
          0: n_data = 0;
          1: n_data = MaxFrameLen - 3;
          default: n_data = $urandom_range(1, MaxFrameLen - 4);
        endcase
        body = {sb.station_addr};
        repeat (n_data) begin
          body.push_back(($urandom_range(7) == 0) ? sb.station_addr : 8'($urandom));
        end
        send_frame(body, kind >= 65);
      end else if (kind < 87) begin
        send_byte(sb.station_addr);
        repeat ($urandom_range(MaxFrameLen - 1, MaxFrameLen + 5)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
      // run out any broken frame so the next one starts from idle
      while (sb.receiving) send_byte(8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_station_address(SlaveAddrRst);
    run_directed();
    finish_phase();

    write_station_address(8'd240);
    tx_idle_pct = 27;
    rx_idle_pct = 70;
    run_traffic(400);
    finish_phase();

    write_station_address(8'($urandom_range(2, 239)));
    tx_idle_pct = 70;
    rx_idle_pct = 27;
    run_traffic(400);
    finish_phase();

    // long result hold-off while bytes keep coming, so the input backs up
    write_station_address(8'd1);
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    long_hold_req = 60;
    run_traffic(200);
    finish_phase();

    write_station_address(8'($urandom_range(1, 240)));
    run_traffic(200);
    finish_phase();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rtufr_pkg.sv
src/rtufr_in_reg.sv
src/rtufr_proc.sv
src/rtufr_out_reg.sv
src/rtu_frame_receiver_crc16_core.sv
tb/tb_rtu_frame_receiver_crc16_core.sv
